// ----- hdl/tvsd_pkg.sv -----
// tvsd_pkg: shared types, codes and helpers for the tagged value stream decoder
`timescale 1ns / 1ps
`default_nettype none
package tvsd_pkg;

  // parser modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_FIELD  = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_TLEN   = 2'd3;

  // token kinds, plus two internal pending kinds
  localparam logic [3:0] K_NIL    = 4'd0;
  localparam logic [3:0] K_BOOL   = 4'd1;
  localparam logic [3:0] K_INT    = 4'd2;
  localparam logic [3:0] K_FLOAT  = 4'd3;
  localparam logic [3:0] K_STR    = 4'd4;
  localparam logic [3:0] K_SBYTE  = 4'd5;
  localparam logic [3:0] K_TSTART = 4'd6;
  localparam logic [3:0] K_TEND   = 4'd7;
  localparam logic [3:0] K_PTR    = 4'd8;
  localparam logic [3:0] K_ERR    = 4'd9;
  localparam logic [3:0] K_STRLEN = 4'd10;
  localparam logic [3:0] K_TLEN   = 4'd11;

  // type field of a type byte
  localparam logic [2:0] T_NIL   = 3'd0;
  localparam logic [2:0] T_BOOL  = 3'd1;
  localparam logic [2:0] T_INT   = 3'd2;
  localparam logic [2:0] T_FLOAT = 3'd3;
  localparam logic [2:0] T_SSTR  = 3'd4;
  localparam logic [2:0] T_LSTR  = 3'd5;
  localparam logic [2:0] T_TABLE = 3'd6;

  // slot roles
  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_KEY   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_COOKIE   = 3'd1;
  localparam logic [2:0] ERR_TLEN     = 3'd2;
  localparam logic [2:0] ERR_DEEP     = 3'd3;
  localparam logic [2:0] ERR_LENGTH   = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;

  // configuration register indexes
  localparam logic REG_MAX_DEPTH  = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  localparam logic [4:0] COOKIE_LONG = 5'd31;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  field_left;
    logic [3:0]  field_total;
    logic [63:0] word;
    logic [30:0] str_left;
    logic [3:0]  pend;
    logic        err;
  } pstate_t;

  typedef struct packed {
    logic [30:0] count;
    logic [1:0]  phase;
  } entry_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [5:0]  level;
    logic [1:0]  role;
    logic [2:0]  code;
  } token_t;

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    case (n)
      4'd1:    r = {{56{v[7]}}, v[7:0]};
      4'd2:    r = {{48{v[15]}}, v[15:0]};
      4'd4:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // integer and table length width from cookie 1..4
  function automatic logic [3:0] int_width(input logic [4:0] c);
    logic [3:0] r;
    case (c)
      5'd1:    r = 4'd1;
      5'd2:    r = 4'd2;
      5'd3:    r = 4'd4;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] str_width(input logic [4:0] c);
    logic [3:0] r;
    case (c)
      5'd1:    r = 4'd1;
      5'd2:    r = 4'd2;
      5'd4:    r = 4'd4;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic bad_len(input logic [63:0] v, input logic [30:0] maxl);
    return v[63] || (v[62:31] != 32'd0) || (v[30:0] > maxl);
  endfunction

  function automatic logic [1:0] entry_role(input entry_t e);
    return (e.count != 31'd0) ? ROLE_NONE : e.phase;
  endfunction

  function automatic entry_t entry_adv(input entry_t e);
    entry_t r;
    r = e;
    if (e.count != 31'd0) begin
      r.count = e.count - 31'd1;
    end else begin
      r.phase = (e.phase == ROLE_KEY) ? ROLE_VALUE : ROLE_KEY;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tvsd_stack.sv -----
// tvsd_stack: memory for the table entries below the cached top of stack
`timescale 1ns / 1ps
`default_nettype none
module tvsd_stack import tvsd_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // forward a same-cycle write so the entry below the top is always current
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tvsd_parse.sv -----
// tvsd_parse: next-state and token logic for one stream byte
`timescale 1ns / 1ps
`default_nettype none
module tvsd_parse import tvsd_pkg::*; #(
  parameter int STACK_DEPTH   = 32,
  parameter int POINTER_BYTES = 8,
  parameter int LW            = 6,
  parameter int AW            = 5
) (
  input  wire pstate_t       st,
  input  wire logic [LW-1:0] level,
  input  wire entry_t        top,
  input  wire entry_t        below,
  input  wire logic [7:0]    data_byte,
  input  wire logic          stream_end,
  input  wire logic [5:0]    depth_limit,
  input  wire logic [30:0]   max_length,
  output pstate_t            st_next,
  output logic [LW-1:0]      level_next,
  output entry_t             top_next,
  output logic               push_we,
  output logic [AW-1:0]      push_addr,
  output logic               have,
  output token_t             tok
);

  function automatic token_t make_tok(input logic [3:0] kind, input logic [63:0] value,
                                      input logic [LW-1:0] lvl, input entry_t e);
    token_t r;
    r.kind  = kind;
    r.value = value;
    r.level = 6'(lvl);
    r.role  = (lvl != '0) ? entry_role(e) : ROLE_NONE;
    r.code  = ERR_NONE;
    return r;
  endfunction

  always_comb begin
    logic [2:0]    t;
    logic [4:0]    c;
    logic [2:0]    idx;
    logic [63:0]   w_new;
    logic [3:0]    left_new;
    logic          do_str;
    logic          do_open;
    logic          do_adv;
    logic [63:0]   len;
    logic [2:0]    err_now;
    logic [2:0]    code;
    logic [LW-1:0] lvl;
    entry_t        cur;

    t        = data_byte[2:0];
    c        = data_byte[7:3];
    idx      = 3'(st.field_total - st.field_left);
    w_new    = st.word | (64'(data_byte) << {idx, 3'b000});
    left_new = st.field_left - 4'd1;
    do_str   = 1'b0;
    do_open  = 1'b0;
    do_adv   = 1'b0;
    len      = '0;
    err_now  = ERR_NONE;
    code     = ERR_NONE;
    lvl      = level;
    cur      = top;
    st_next  = st;
    push_we  = 1'b0;
    push_addr = '0;
    have     = 1'b0;
    tok      = '0;

    if (st.err) begin
      if (stream_end) begin
        st_next = '0;
        lvl     = '0;
      end
    end else begin
      case (st.mode)
        MODE_IDLE: begin
          case (t)
            T_NIL: begin
              if (lvl != '0 && entry_role(cur) == ROLE_KEY) begin
                lvl  = lvl - LW'(1);
                cur  = below;
                have = 1'b1;
                tok  = make_tok(K_TEND, 64'd0, lvl, cur);
              end else begin
                have = 1'b1;
                tok  = make_tok(K_NIL, 64'd0, lvl, cur);
              end
              do_adv = 1'b1;
            end
            T_BOOL: begin
              have   = 1'b1;
              tok    = make_tok(K_BOOL, (c != 5'd0) ? 64'd1 : 64'd0, lvl, cur);
              do_adv = 1'b1;
            end
            T_INT: begin
              if (c == 5'd0) begin
                have   = 1'b1;
                tok    = make_tok(K_INT, 64'd0, lvl, cur);
                do_adv = 1'b1;
              end else if (c <= 5'd4) begin
                st_next.mode        = MODE_FIELD;
                st_next.pend        = K_INT;
                st_next.field_left  = int_width(c);
                st_next.field_total = int_width(c);
                st_next.word        = '0;
              end else begin
                err_now = ERR_COOKIE;
              end
            end
            T_FLOAT: begin
              st_next.mode        = MODE_FIELD;
              st_next.pend        = K_FLOAT;
              st_next.field_left  = 4'd8;
              st_next.field_total = 4'd8;
              st_next.word        = '0;
            end
            T_SSTR: begin
              do_str = 1'b1;
              len    = 64'(c);
            end
            T_LSTR: begin
              st_next.mode        = MODE_FIELD;
              st_next.pend        = K_STRLEN;
              st_next.field_left  = str_width(c);
              st_next.field_total = str_width(c);
              st_next.word        = '0;
            end
            T_TABLE: begin
              if (32'(lvl) >= 32'(depth_limit) || 32'(lvl) >= STACK_DEPTH) begin
                err_now = ERR_DEEP;
              end else if (c != COOKIE_LONG) begin
                do_open = 1'b1;
                len     = 64'(c);
              end else begin
                st_next.mode = MODE_TLEN;
              end
            end
            default: begin
              st_next.mode        = MODE_FIELD;
              st_next.pend        = K_PTR;
              st_next.field_left  = 4'(POINTER_BYTES);
              st_next.field_total = 4'(POINTER_BYTES);
              st_next.word        = '0;
            end
          endcase
        end
        MODE_FIELD: begin
          st_next.word       = w_new;
          st_next.field_left = left_new;
          if (left_new == 4'd0) begin
            st_next.mode = MODE_IDLE;
            case (st.pend)
              K_INT: begin
                have   = 1'b1;
                tok    = make_tok(K_INT, sext(w_new, st.field_total), lvl, cur);
                do_adv = 1'b1;
              end
              K_FLOAT, K_PTR: begin
                have   = 1'b1;
                tok    = make_tok(st.pend, w_new, lvl, cur);
                do_adv = 1'b1;
              end
              K_STRLEN: begin
                do_str = 1'b1;
                len    = sext(w_new, st.field_total);
              end
              default: begin
                do_open = 1'b1;
                len     = sext(w_new, st.field_total);
              end
            endcase
          end
        end
        MODE_STRING: begin
          have = 1'b1;
          tok  = make_tok(K_SBYTE, 64'(data_byte), lvl, cur);
          if (st.str_left > 31'd1) begin
            st_next.str_left = st.str_left - 31'd1;
          end else begin
            st_next.str_left = '0;
            st_next.mode     = MODE_IDLE;
            do_adv           = 1'b1;
          end
        end
        default: begin
          st_next.mode = MODE_IDLE;
          if (t != T_INT) begin
            err_now = ERR_TLEN;
          end else if (c == 5'd0) begin
            do_open = 1'b1;
            len     = '0;
          end else if (c <= 5'd4) begin
            st_next.mode        = MODE_FIELD;
            st_next.pend        = K_TLEN;
            st_next.field_left  = int_width(c);
            st_next.field_total = int_width(c);
            st_next.word        = '0;
          end else begin
            err_now = ERR_COOKIE;
          end
        end
      endcase

      if (do_str) begin
        if (bad_len(len, max_length)) begin
          err_now = ERR_LENGTH;
        end else begin
          have = 1'b1;
          tok  = make_tok(K_STR, len, lvl, cur);
          if (len == 64'd0) begin
            do_adv = 1'b1;
          end else begin
            st_next.str_left = len[30:0];
            st_next.mode     = MODE_STRING;
          end
        end
      end

      if (do_open) begin
        if (bad_len(len, max_length)) begin
          err_now = ERR_LENGTH;
        end else if (32'(lvl) >= STACK_DEPTH) begin
          err_now = ERR_DEEP;
        end else begin
          have = 1'b1;
          tok  = make_tok(K_TSTART, len, lvl, cur);
          // spill the old top below the new one
          push_we   = (lvl != '0);
          push_addr = AW'(lvl - LW'(1));
          cur.count = len[30:0];
          cur.phase = ROLE_KEY;
          lvl       = lvl + LW'(1);
        end
      end

      if (do_adv && lvl != '0) begin
        cur = entry_adv(cur);
      end

      code = err_now;
      if (err_now != ERR_NONE) begin
        have = 1'b0;
        if (stream_end) begin
          st_next = '0;
          lvl     = '0;
        end else begin
          st_next.err = 1'b1;
        end
      end else if (stream_end) begin
        if (st_next.mode != MODE_IDLE || lvl != '0) begin
          code = ERR_TRUNC;
        end
        st_next = '0;
        lvl     = '0;
      end

      if (have) begin
        tok.code = code;
      end else if (code != ERR_NONE) begin
        have       = 1'b1;
        tok.kind   = K_ERR;
        tok.value  = '0;
        tok.level  = 6'(lvl);
        tok.role   = ROLE_NONE;
        tok.code   = code;
      end
    end

    level_next = lvl;
    top_next   = cur;
  end

endmodule
`default_nettype wire

// ----- hdl/tagged_value_stream_decoder.sv -----
// tagged_value_stream_decoder: top level, state registers, config and output buffer
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  in       | to block  | in_valid / in_stall    | data_byte, stream_end
//  out      | from block| out_valid / out_stall  | token_kind, token_value, nest_level,
//           |           |                        | slot_role, error_code
//  cfg      | to block  | cfg_we                 | cfg_index, cfg_data
//
// one byte per cycle while in_stall is low: a transfer on in updates the parser state
// at that edge and its token (if any) lands in the output register or the skid, so the
// next byte can follow at once; the cycle limit is the single stack-top access: top is
// cached in flops, the entry below it is prefetched from the stack memory for table close
// a two-entry output buffer (output register plus skid) holds tokens while out stalls;
// in_stall rises only when both are full
// rst clears parser state and valids, presets config regs; stack memory needs no clear
`timescale 1ns / 1ps
`default_nettype none
module tagged_value_stream_decoder import tvsd_pkg::*; #(
  parameter int STACK_DEPTH   = 32,
  parameter int POINTER_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_end,
  // token stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic [63:0]      token_value,
  output logic [5:0]       nest_level,
  output logic [1:0]       slot_role,
  output logic [2:0]       error_code,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // config registers
  logic [5:0]  depth_limit;
  logic [30:0] max_length;

  // parser state
  pstate_t       st;
  pstate_t       st_next;
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [LW-1:0] level_sel;
  entry_t        top;
  entry_t        top_next;
  entry_t        below;

  logic          push_we;
  logic [AW-1:0] push_addr;
  logic          have;
  token_t        tok;

  // output buffer
  token_t out_tok;
  token_t skid_tok;
  logic   skid_valid;

  logic accept;
  logic out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 6'd32;
      max_length  <= 31'h7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DEPTH:  depth_limit <= cfg_data[5:0];
        REG_MAX_LENGTH: max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  tvsd_parse #(
    .STACK_DEPTH   (STACK_DEPTH),
    .POINTER_BYTES (POINTER_BYTES),
    .LW            (LW),
    .AW            (AW)
  ) u_parse (
    .st          (st),
    .level       (level),
    .top         (top),
    .below       (below),
    .data_byte   (data_byte),
    .stream_end  (stream_end),
    .depth_limit (depth_limit),
    .max_length  (max_length),
    .st_next     (st_next),
    .level_next  (level_next),
    .top_next    (top_next),
    .push_we     (push_we),
    .push_addr   (push_addr),
    .have        (have),
    .tok         (tok)
  );

  // prefetch the entry under the new top
  assign level_sel = accept ? level_next : level;

  tvsd_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (accept && push_we),
    .waddr (push_addr),
    .wdata (top),
    .raddr (AW'(level_sel - LW'(2))),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      level <= '0;
    end else if (accept) begin
      st    <= st_next;
      level <= level_next;
    end
  end

  // top entry is only read while level is nonzero, so it needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      top <= top_next;
    end
  end

  // output register and skid valids
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && have) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // buffer payloads
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_tok <= skid_tok;
      end
    end else if (accept && have) begin
      if (out_free) begin
        out_tok <= tok;
      end else begin
        skid_tok <= tok;
      end
    end
  end

  assign token_kind  = out_tok.kind;
  assign token_value = out_tok.value;
  assign nest_level  = out_tok.level;
  assign slot_role   = out_tok.role;
  assign error_code  = out_tok.code;

  // a full skid always sits behind a valid output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid holds a token while the output register is empty");

  // nesting never passes the stack size
  assert property (@(posedge clk) disable iff (rst) 32'(level) <= STACK_DEPTH)
    else $error("nesting level beyond stack depth");

  // string body mode always has bytes left to consume
  assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_STRING |-> st.str_left != 31'd0)
    else $error("string mode with no bytes left");

  // field mode always has bytes left to assemble
  assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_FIELD |-> st.field_left != 4'd0)
    else $error("field mode with no bytes left");

endmodule
`default_nettype wire
